// ===== design/tps_pkg.sv =====
// shared types and constants of the triangle plane slicer
`default_nettype none

package tps_pkg;

   localparam int COORD_W     = 32;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int PROD_W      = DIFF_W + COORD_W;
   localparam int DIST_W      = PROD_W + 2;
   localparam int DEN_W       = DIST_W + 1;
   localparam int PP_LO_W     = 34;
   localparam int PP_HI_W     = DIST_W - PP_LO_W;
   localparam int PP0_W       = DIFF_W + PP_LO_W;
   localparam int PP1_W       = DIFF_W + PP_HI_W;
   localparam int NUM_W       = DIFF_W + DIST_W;
   localparam int NN_W        = NUM_W + 1;
   localparam int DD_W        = DEN_W + 1;
   localparam int QUOT_W      = DIFF_W + 1;
   localparam int REM_W       = DD_W;
   localparam int SUM_W       = QUOT_W + 2;
   localparam int BACK_STAGES = QUOT_W + 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_POINT_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_POINT_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_POINT_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NORMAL_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NORMAL_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NORMAL_Z = 3'd5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIST_W-1:0]  dist_type;

   localparam coord_type PLANE_NORMAL_Z_RESET = 32'sd65536;

   typedef struct packed {
      coord_type vert0_x;
      coord_type vert0_y;
      coord_type vert0_z;
      coord_type vert1_x;
      coord_type vert1_y;
      coord_type vert1_z;
      coord_type vert2_x;
      coord_type vert2_y;
      coord_type vert2_z;
   } req_type;

   typedef struct packed {
      coord_type seg_start_x;
      coord_type seg_start_y;
      coord_type seg_start_z;
      coord_type seg_end_x;
      coord_type seg_end_y;
      coord_type seg_end_z;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [COORD_W-1:0]   wdata;
   } csr_type;

   typedef struct packed {
      coord_type [2:0] pa;
      coord_type [2:0] pb;
      dist_type        da;
      dist_type        db;
   } cross_type;

   typedef struct packed {
      cross_type [1:0] cr;
   } job_type;

endpackage

`default_nettype wire

// ===== design/tps_if.sv =====
// valid/ready channel interfaces of the triangle plane slicer
`default_nettype none

interface tps_req_if
   import tps_pkg::*;
   ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tps_rsp_if
   import tps_pkg::*;
   ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tps_csr_if
   import tps_pkg::*;
   ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/triangle_plane_slicer_core.sv =====
// Triangle / plane slicer core.
// req_ch carries one triangle per transaction (three vertices, signed fixed
// point). rsp_ch carries one segment per triangle that crosses the plane: the
// first crossing in edge order (v0v1, v1v2, v2v0) is the start, the second
// the end. Triangles that do not cross produce no transaction.
// csr_ch writes the plane point (indexes 0..2) and the plane normal (3..5);
// it is always ready and should be written only while the core is idle.
// An accepted triangle reaches its segment on rsp_ch through the distance
// and product stages, the queue and the 34-stage rounding divider of each
// crossing coordinate.
// Throughput: one triangle per cycle while rsp_ch and the queue do not stall; every stage is fully pipelined.
// A 4-entry queue sits between the distance front end and the crossing back
// end, so a stall on rsp_ch holds the back end only; the front end keeps
// accepting triangles until the queue is full and a crossing one waits for it.
// Synchronous reset empties the pipelines and the queue and sets the plane
// to point (0,0,0) and normal (0,0,1.0).
`default_nettype none

module triangle_plane_slicer_core
   import tps_pkg::*;
   (
   input  logic      clock,
   input  logic      reset,
   tps_req_if.sink   req_ch,
   tps_rsp_if.source rsp_ch,
   tps_csr_if.sink   csr_ch
   );

   logic    push;
   job_type push_data;
   logic    full;
   logic    pop;
   job_type pop_data;
   logic    empty;

   assign csr_ch.ready = 1'b1;

   tps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (req_ch.data),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.data.index),
      .csr_wdata (csr_ch.data.wdata),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   tps_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   tps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (pop_data),
      .empty     (empty),
      .pop       (pop),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_ch.data)
   );

endmodule

`default_nettype wire

// ===== design/tps_front.sv =====
// front end: plane registers, vertex distances and edge classification
`default_nettype none

module tps_front
   import tps_pkg::*;
   (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  req_type              in_data,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   output logic                 push,
   output job_type              push_data,
   input  logic                 full
   );

   coord_type pp_ff [3];
   coord_type pn_ff [3];

   coord_type vtx [3][3];

   logic                     a_vld_ff;
   coord_type                a_vtx_ff [3][3];
   logic signed [DIFF_W-1:0] a_e_ff [3][3];

   logic                     b_vld_ff;
   coord_type                b_vtx_ff [3][3];
   logic signed [PROD_W-1:0] b_prod_ff [3][3];
   logic signed [PROD_W-1:0] b_prod_in [3][3];

   logic      c_vld_ff;
   coord_type c_vtx_ff [3][3];
   dist_type  c_d_ff [3];
   dist_type  c_d_in [3];

   logic       fen;
   logic [2:0] side;
   logic [2:0] crossed;
   logic       c_cross;
   cross_type  edges [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff[0] <= '0;
         pp_ff[1] <= '0;
         pp_ff[2] <= '0;
         pn_ff[0] <= '0;
         pn_ff[1] <= '0;
         pn_ff[2] <= PLANE_NORMAL_Z_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PLANE_POINT_X:  pp_ff[0] <= csr_wdata;
            CSR_PLANE_POINT_Y:  pp_ff[1] <= csr_wdata;
            CSR_PLANE_POINT_Z:  pp_ff[2] <= csr_wdata;
            CSR_PLANE_NORMAL_X: pn_ff[0] <= csr_wdata;
            CSR_PLANE_NORMAL_Y: pn_ff[1] <= csr_wdata;
            CSR_PLANE_NORMAL_Z: pn_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      vtx[0][0] = in_data.vert0_x;
      vtx[0][1] = in_data.vert0_y;
      vtx[0][2] = in_data.vert0_z;
      vtx[1][0] = in_data.vert1_x;
      vtx[1][1] = in_data.vert1_y;
      vtx[1][2] = in_data.vert1_z;
      vtx[2][0] = in_data.vert2_x;
      vtx[2][1] = in_data.vert2_y;
      vtx[2][2] = in_data.vert2_z;
   end

   assign fen      = !(c_vld_ff && c_cross && full);
   assign in_ready = fen;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (fen) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            b_prod_in[i][k] = a_e_ff[i][k] * pn_ff[k];
         end
      end
      for (int i = 0; i < 3; i++) begin
         c_d_in[i] = {{2{b_prod_ff[i][0][PROD_W-1]}}, b_prod_ff[i][0]}
                   + {{2{b_prod_ff[i][1][PROD_W-1]}}, b_prod_ff[i][1]}
                   + {{2{b_prod_ff[i][2][PROD_W-1]}}, b_prod_ff[i][2]};
      end
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               a_vtx_ff[i][k]  <= vtx[i][k];
               a_e_ff[i][k]    <= {vtx[i][k][COORD_W-1], vtx[i][k]}
                                - {pp_ff[k][COORD_W-1], pp_ff[k]};
               b_vtx_ff[i][k]  <= a_vtx_ff[i][k];
               b_prod_ff[i][k] <= b_prod_in[i][k];
               c_vtx_ff[i][k]  <= b_vtx_ff[i][k];
            end
            c_d_ff[i] <= c_d_in[i];
         end
      end
   end

   // edge order is (v0,v1), (v1,v2), (v2,v0)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         side[i] = c_d_ff[i][DIST_W-1];
      end
      crossed = {side[2] ^ side[0], side[1] ^ side[2], side[0] ^ side[1]};
      c_cross = crossed inside {3'b011, 3'b101, 3'b110};
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            edges[i].pa[k] = c_vtx_ff[i][k];
            edges[i].pb[k] = c_vtx_ff[(i + 1) % 3][k];
         end
         edges[i].da = c_d_ff[i];
         edges[i].db = c_d_ff[(i + 1) % 3];
      end
      push_data.cr[0] = crossed[0] ? edges[0] : edges[1];
      push_data.cr[1] = crossed[2] ? edges[2] : edges[1];
   end

   assign push = c_vld_ff && c_cross && !full;

endmodule

`default_nettype wire

// ===== design/tps_fifo.sv =====
// short job queue between the front end and the back end
`default_nettype none

module tps_fifo
   import tps_pkg::*;
   (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
   );

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff;
   logic [QPTR_W-1:0]   rptr_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic [QCNT_W-1:0]   cnt_in;

   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/tps_lane.sv =====
// one crossing coordinate: scaled product, pipelined rounding divider, clamp
`default_nettype none

module tps_lane
   import tps_pkg::*;
   (
   input  logic      clock,
   input  logic      en,
   input  coord_type a,
   input  coord_type b,
   input  dist_type  da,
   input  dist_type  db,
   output coord_type res
   );

   logic signed [DIFF_W-1:0] diff;
   logic signed [DEN_W-1:0]  den;

   logic [DIFF_W-1:0] s0_dm_ff;
   logic [DIST_W-1:0] s0_ada_ff;
   logic [DEN_W-1:0]  s0_aden_ff;
   logic              s0_neg_ff;
   coord_type         s0_a_ff;

   logic [PP0_W-1:0] s1_pp0_ff;
   logic [PP1_W-1:0] s1_pp1_ff;
   logic [DEN_W-1:0] s1_aden_ff;
   logic             s1_neg_ff;
   coord_type        s1_a_ff;

   logic [NUM_W-1:0] num;
   logic [NN_W-1:0]  nn;

   logic [REM_W-1:0]  rem_ff [QUOT_W+1];
   logic [QUOT_W-1:0] low_ff [QUOT_W+1];
   logic [QUOT_W-1:0] q_ff   [QUOT_W+1];
   logic [DD_W-1:0]   dd_ff  [QUOT_W+1];
   logic              neg_ff [QUOT_W+1];
   coord_type         ca_ff  [QUOT_W+1];

   logic [SUM_W-1:0]        mag;
   logic signed [SUM_W-1:0] off;
   logic signed [SUM_W-1:0] sum;
   coord_type               res_ff;
   coord_type               res_in;

   assign diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
   assign den  = {da[DIST_W-1], da} - {db[DIST_W-1], db};

   always_ff @(posedge clock) begin
      if (en) begin
         s0_dm_ff   <= diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
         s0_ada_ff  <= da[DIST_W-1] ? (~da + 1'b1) : da;
         s0_aden_ff <= den[DEN_W-1] ? (~den + 1'b1) : den;
         s0_neg_ff  <= diff[DIFF_W-1] ^ da[DIST_W-1] ^ den[DEN_W-1];
         s0_a_ff    <= a;

         s1_pp0_ff  <= s0_dm_ff * s0_ada_ff[PP_LO_W-1:0];
         s1_pp1_ff  <= s0_dm_ff * s0_ada_ff[DIST_W-1:PP_LO_W];
         s1_aden_ff <= s0_aden_ff;
         s1_neg_ff  <= s0_neg_ff;
         s1_a_ff    <= s0_a_ff;
      end
   end

   // rounded quotient of (2*num + den) / (2*den)
   assign num = {{(NUM_W-PP0_W){1'b0}}, s1_pp0_ff} + {s1_pp1_ff, {PP_LO_W{1'b0}}};
   assign nn  = {num, 1'b0} + {{(NN_W-DEN_W){1'b0}}, s1_aden_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {{(REM_W-(NN_W-QUOT_W)){1'b0}}, nn[NN_W-1:QUOT_W]};
         low_ff[0] <= nn[QUOT_W-1:0];
         q_ff[0]   <= '0;
         dd_ff[0]  <= {s1_aden_ff, 1'b0};
         neg_ff[0] <= s1_neg_ff;
         ca_ff[0]  <= s1_a_ff;
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      logic [REM_W:0] trial;
      logic [REM_W:0] sub;
      logic           ge;

      assign trial = {rem_ff[k], low_ff[k][QUOT_W-1]};
      assign sub   = trial - {1'b0, dd_ff[k]};
      assign ge    = (trial >= {1'b0, dd_ff[k]});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? sub[REM_W-1:0] : trial[REM_W-1:0];
            low_ff[k+1] <= {low_ff[k][QUOT_W-2:0], 1'b0};
            q_ff[k+1]   <= {q_ff[k][QUOT_W-2:0], ge};
            dd_ff[k+1]  <= dd_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ca_ff[k+1]  <= ca_ff[k];
         end
      end
   end

   always_comb begin
      mag = {2'b00, q_ff[QUOT_W]};
      off = neg_ff[QUOT_W] ? -$signed(mag) : $signed(mag);
      sum = {{(SUM_W-COORD_W){ca_ff[QUOT_W][COORD_W-1]}}, ca_ff[QUOT_W]} + off;
      if (sum > $signed({{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}})) begin
         res_in = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (sum < $signed({{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}})) begin
         res_in = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         res_in = sum[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ===== design/tps_back.sv =====
// back end: six crossing lanes and the result register
`default_nettype none

module tps_back
   import tps_pkg::*;
   (
   input  logic    clock,
   input  logic    reset,
   input  job_type job,
   input  logic    empty,
   output logic    pop,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
   );

   logic      vld_ff [BACK_STAGES];
   logic      ben;
   coord_type res [2][3];

   assign ben       = !vld_ff[BACK_STAGES-1] || out_ready;
   assign pop       = ben && !empty;
   assign out_valid = vld_ff[BACK_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < BACK_STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (ben) begin
         vld_ff[0] <= pop;
         for (int s = 1; s < BACK_STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   for (genvar j = 0; j < 2; j++) begin : g_pt
      for (genvar k = 0; k < 3; k++) begin : g_ax
         tps_lane u_lane (
            .clock (clock),
            .en    (ben),
            .a     (job.cr[j].pa[k]),
            .b     (job.cr[j].pb[k]),
            .da    (job.cr[j].da),
            .db    (job.cr[j].db),
            .res   (res[j][k])
         );
      end
   end

   always_comb begin
      out_data.seg_start_x = res[0][0];
      out_data.seg_start_y = res[0][1];
      out_data.seg_start_z = res[0][2];
      out_data.seg_end_x   = res[1][0];
      out_data.seg_end_y   = res[1][1];
      out_data.seg_end_z   = res[1][2];
   end

endmodule

`default_nettype wire

// ===== design/tps_checker.sv =====
// port-level checks of the slicer core and their bind
`default_nettype none

module tps_checker
   import tps_pkg::*;
   (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data,
   input logic    csr_ready
   );

   a_rsp_clear_on_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("segment valid right after reset");

   a_rsp_not_early: assert property (@(posedge clock)
      reset ##1 !reset |=> !rsp_valid)
      else $error("segment shown before any triangle could get through");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled segment dropped or changed");

   a_csr_ready: assert property (@(posedge clock)
      !reset |-> csr_ready)
      else $error("register port not ready");

endmodule

bind triangle_plane_slicer_core tps_checker u_tps_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data),
   .csr_ready (csr_ch.ready)
);

`default_nettype wire
